// ----- sv/dbp_pkg.sv -----
// ----------------------------------------------------------------------------
// dbp_pkg
// shared byte codes, parser phases and the result beat layout for the
// meter data block parser
// ----------------------------------------------------------------------------
package dbp_pkg;

  // control characters of the data block
  localparam logic [7:0] CH_STX   = 8'h02;
  localparam logic [7:0] CH_ETX   = 8'h03;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;

  // block check modes
  localparam logic CHECK_SUM = 1'b0;
  localparam logic CHECK_XOR = 1'b1;

  // progress through the "ERRnn" pattern
  localparam logic [2:0] EP_START        = 3'd0;
  localparam logic [2:0] EP_LAST_LETTER  = 3'd3;
  localparam logic [2:0] EP_SECOND_DIGIT = 3'd4;
  localparam logic [2:0] EP_MATCHED      = 3'd5;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned VALUE_W = 32;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_VALUE,
    PH_AFTER,
    PH_CHECK,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  row_address;
    logic [3:0]         address_length;
    logic               address_truncated;
    logic [VALUE_W-1:0] row_value;
    logic               value_wrapped;
    logic               value_present;
    logic               meter_error;
    logic [6:0]         meter_error_code;
    logic               start_error;
    logic               check_ok;
    logic               block_end;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

endpackage

// ----- sv/meter_data_block_parser_top.sv -----
// ----------------------------------------------------------------------------
// meter_data_block_parser_top
// streaming parser for a meter data block: STX, ADDR(VALUE) CR LF rows,
// ETX and the block check byte
// ----------------------------------------------------------------------------
// usage
//   input channel: one received byte per beat (rx_byte_i), frame_begin_i
//   high on the first byte of a response restarts the parser
//   output channel: one result beat per row closed by CR LF, and one with
//   block_end_o high for the block check byte; other bytes give no beat
//   config channel: cfg_check_mode_i selects the block check, 0 byte sum
//   modulo 256, 1 exclusive or; always ready, write it while idle
//   result path: the byte lands in the input register, and the parse step
//   fills the result register from it once the result register can take
//   a new beat
//   throughput: one byte per cycle unless the result register stalls, set
//   by the combinational parse step that updates the row state per byte
//   stall: when the result register is full and out_ready_i is low, the
//   input register holds its byte and in_ready_o drops once it is full;
//   nothing is lost or repeated
//   reset: parser waits for a frame start, check mode back to byte sum,
//   both pipeline registers empty
// ----------------------------------------------------------------------------
module meter_data_block_parser_top #(
  parameter int unsigned ADDRESS_CHARS = 8,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_begin_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] row_address_o,
  output logic [3:0]  address_length_o,
  output logic        address_truncated_o,
  output logic [31:0] row_value_o,
  output logic        value_wrapped_o,
  output logic        value_present_o,
  output logic        meter_error_o,
  output logic [6:0]  meter_error_code_o,
  output logic        start_error_o,
  output logic        check_ok_o,
  output logic        block_end_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_check_mode_i
);

  import dbp_pkg::*;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_begin_q;

  // result register
  logic    out_valid_q;
  result_t out_res_q;

  logic    check_mode_q;
  logic    advance;
  logic    step;
  logic    res_valid;
  result_t res;

  // the result register can take a new beat this cycle
  assign advance     = !out_valid_q || out_ready_i;
  assign step        = s1_valid_q && advance;
  assign in_ready_o  = !s1_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q <= CHECK_SUM;
    end else if (cfg_valid_i) begin
      check_mode_q <= cfg_check_mode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q  <= rx_byte_i;
      s1_begin_q <= frame_begin_i;
    end
  end

  dbp_parse_core #(
    .ADDRESS_CHARS (ADDRESS_CHARS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_parse_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_byte_i     (s1_byte_q),
    .frame_begin_i (s1_begin_q),
    .check_mode_i  (check_mode_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign row_address_o       = out_res_q.row_address;
  assign address_length_o    = out_res_q.address_length;
  assign address_truncated_o = out_res_q.address_truncated;
  assign row_value_o         = out_res_q.row_value;
  assign value_wrapped_o     = out_res_q.value_wrapped;
  assign value_present_o     = out_res_q.value_present;
  assign meter_error_o       = out_res_q.meter_error;
  assign meter_error_code_o  = out_res_q.meter_error_code;
  assign start_error_o       = out_res_q.start_error;
  assign check_ok_o          = out_res_q.check_ok;
  assign block_end_o         = out_res_q.block_end;

endmodule

// ----- sv/dbp_value_acc.sv -----
// ----------------------------------------------------------------------------
// dbp_value_acc
// one decimal digit step of the value accumulator: acc * 10 + digit,
// with a flag when the result no longer fits
// ----------------------------------------------------------------------------
module dbp_value_acc #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [3:0]            digit_i,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic                  wrap_o
);

  logic [VALUE_BITS+3:0] acc_wide;
  logic [VALUE_BITS+3:0] prod;

  // times ten as two shifts and an add
  assign acc_wide = {4'b0000, acc_i};
  assign prod     = (acc_wide << 3) + (acc_wide << 1) + {{VALUE_BITS{1'b0}}, digit_i};

  assign acc_o  = prod[VALUE_BITS-1:0];
  assign wrap_o = |prod[VALUE_BITS+3:VALUE_BITS];

endmodule

// ----- sv/dbp_parse_core.sv -----
// ----------------------------------------------------------------------------
// dbp_parse_core
// parser state and the per-byte update; gives at most one result per byte
// ----------------------------------------------------------------------------
module dbp_parse_core #(
  parameter int unsigned ADDRESS_CHARS = 8,
  parameter int unsigned VALUE_BITS    = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  input  logic             frame_begin_i,
  input  logic             check_mode_i,
  output logic             res_valid_o,
  output dbp_pkg::result_t res_o
);

  import dbp_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0]     addr;
    logic [3:0]            count;
    logic                  overflow;
    logic [VALUE_BITS-1:0] acc;
    logic                  present;
    logic                  stopped;
    logic                  wrapped;
    logic                  ep_bad;
    logic [2:0]            ep_pos;
    logic [6:0]            err_digits;
    logic                  cr_pending;
  } row_t;

  phase_e     phase_q, phase_d;
  row_t       row_q, row_d;
  logic [7:0] check_q, check_d;
  logic       first_q, first_d;
  logic       missing_q, missing_d;

  logic                  run_row;
  logic                  row_done;
  logic                  digit;
  logic                  err_match;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  acc_wrap;

  assign digit = is_digit(rx_byte_i);

  dbp_value_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_value_acc (
    .acc_i   (row_q.acc),
    .digit_i (rx_byte_i[3:0]),
    .acc_o   (acc_next),
    .wrap_o  (acc_wrap)
  );

  always_comb begin
    phase_d     = phase_q;
    row_d       = row_q;
    check_d     = check_q;
    first_d     = first_q;
    missing_d   = missing_q;
    run_row     = 1'b0;
    row_done    = 1'b0;
    err_match   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      if (frame_begin_i) begin
        row_d     = '0;
        check_d   = '0;
        first_d   = 1'b1;
        missing_d = (rx_byte_i != CH_STX);
        phase_d   = PH_ADDR;
        run_row   = missing_d;
      end else begin
        case (phase_q)
          PH_IDLE, PH_DONE: begin
            run_row = 1'b0;
          end
          PH_CHECK: begin
            res_valid_o       = 1'b1;
            res_o.start_error = missing_q;
            res_o.check_ok    = (rx_byte_i == check_q);
            res_o.block_end   = 1'b1;
            phase_d           = PH_DONE;
          end
          default: begin
            if (check_mode_i == CHECK_XOR) begin
              check_d = check_q ^ rx_byte_i;
            end else begin
              check_d = check_q + rx_byte_i;
            end
            run_row = 1'b1;
          end
        endcase
      end

      if (run_row) begin
        if (row_d.cr_pending) begin
          row_d.cr_pending = 1'b0;
          if (rx_byte_i == CH_LF) begin
            err_match = first_d && (row_d.count == 4'd0) && !row_d.overflow &&
                        (phase_d == PH_AFTER) && !row_d.ep_bad &&
                        (row_d.ep_pos == EP_MATCHED);
            res_valid_o             = 1'b1;
            res_o.row_address       = row_d.addr;
            res_o.address_length    = row_d.count;
            res_o.address_truncated = row_d.overflow;
            res_o.row_value         = VALUE_W'(row_d.acc);
            res_o.value_wrapped     = row_d.wrapped;
            res_o.value_present     = row_d.present;
            res_o.meter_error       = err_match;
            res_o.meter_error_code  = err_match ? row_d.err_digits : 7'd0;
            res_o.start_error       = missing_d;
            row_d                   = '0;
            first_d                 = 1'b0;
            phase_d                 = PH_ADDR;
            row_done                = 1'b1;
          end
        end

        if (!row_done) begin
          if (rx_byte_i == CH_ETX) begin
            phase_d = PH_CHECK;
          end else if (rx_byte_i == CH_CR) begin
            row_d.cr_pending = 1'b1;
          end else begin
            case (phase_d)
              PH_ADDR: begin
                if (rx_byte_i == CH_OPEN) begin
                  phase_d       = PH_VALUE;
                  row_d.present = 1'b1;
                end else if (row_d.count < 4'(ADDRESS_CHARS)) begin
                  // first character lands in the top byte lane
                  for (int k = 0; k < ADDR_W / 8; k++) begin
                    if (row_d.count == 4'(k)) begin
                      row_d.addr[ADDR_W-1-8*k -: 8] = rx_byte_i;
                    end
                  end
                  row_d.count = row_d.count + 4'd1;
                end else begin
                  row_d.overflow = 1'b1;
                end
              end
              PH_VALUE: begin
                if (rx_byte_i == CH_CLOSE) begin
                  phase_d = PH_AFTER;
                end else begin
                  // error pattern tracker
                  if (!row_d.ep_bad) begin
                    if ((row_d.ep_pos < EP_LAST_LETTER) &&
                        (rx_byte_i == ((row_d.ep_pos == EP_START) ? CH_E : CH_R))) begin
                      row_d.ep_pos = row_d.ep_pos + 3'd1;
                    end else if (((row_d.ep_pos == EP_LAST_LETTER) ||
                                  (row_d.ep_pos == EP_SECOND_DIGIT)) && digit) begin
                      row_d.err_digits = (row_d.err_digits << 3) + (row_d.err_digits << 1)
                                         + {3'b000, rx_byte_i[3:0]};
                      row_d.ep_pos     = row_d.ep_pos + 3'd1;
                    end else begin
                      row_d.ep_bad = 1'b1;
                    end
                  end
                  // decimal value
                  if (!row_d.stopped) begin
                    if (digit) begin
                      row_d.wrapped = row_d.wrapped | acc_wrap;
                      row_d.acc     = acc_next;
                    end else if (rx_byte_i != CH_DOT) begin
                      row_d.stopped = 1'b1;
                    end
                  end
                end
              end
              default: begin
                row_d.stopped = row_d.stopped;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      row_q     <= '0;
      check_q   <= '0;
      first_q   <= 1'b0;
      missing_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      row_q     <= row_d;
      check_q   <= check_d;
      first_q   <= first_d;
      missing_q <= missing_d;
    end
  end

endmodule

// ----- sv/dbp_checker.sv -----
// ----------------------------------------------------------------------------
// dbp_checker
// port-level checks on the result beats of the meter data block parser
// ----------------------------------------------------------------------------
module dbp_checker #(
  parameter int unsigned ADDRESS_CHARS = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] row_address_o,
  input logic [3:0]  address_length_o,
  input logic        address_truncated_o,
  input logic [31:0] row_value_o,
  input logic        value_present_o,
  input logic        meter_error_o,
  input logic [6:0]  meter_error_code_o,
  input logic        check_ok_o,
  input logic        block_end_o
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_address_o) &&
      $stable(row_value_o) && $stable(block_end_o) && $stable(check_ok_o))
    else $error("result beat changed while stalled");

  // block end beat carries no row content
  a_block_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && block_end_o |-> row_address_o == 64'd0 && address_length_o == 4'd0 &&
      row_value_o == 32'd0 && !meter_error_o && !value_present_o)
    else $error("block end beat carries row fields");

  // check result only on block end
  a_check_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !block_end_o |-> !check_ok_o)
    else $error("check_ok on a row beat");

  // truncation only once the address is full
  a_truncated_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && address_truncated_o |-> address_length_o == 4'(ADDRESS_CHARS))
    else $error("address truncated before it was full");

  // a meter error row has an empty address, a value and a small code
  a_meter_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && meter_error_o |-> address_length_o == 4'd0 && value_present_o &&
      row_value_o == 32'd0 && meter_error_code_o <= 7'd99)
    else $error("malformed meter error beat");

endmodule

bind meter_data_block_parser_top dbp_checker #(
  .ADDRESS_CHARS (ADDRESS_CHARS)
) u_dbp_checker (.*);
